@@ rtl/core/srts_pkg.sv @@
// Shared types and constants for the shortest-remaining-time scheduler.
// No dependencies; imported by shortest_remaining_time_scheduler_top.
package srts_pkg;

    // default number of job slots
    localparam int SLOTS_DEF = 16;

    // field widths
    localparam int FUNC_W   = 2;
    localparam int SLOT_F_W = 4;
    localparam int NAME_W   = 8;
    localparam int TIME_W   = 16;
    localparam int TICK_W   = 24;
    localparam int JOBS_W   = 5;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    // item function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NONE  = 2'd3
    } srts_func_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC,
        ST_DONE
    } srts_state_t;

    // one job slot as held in the slot memory
    typedef struct packed {
        logic [TIME_W-1:0] rem;
        logic [TIME_W-1:0] arr;
        logic [TIME_W-1:0] burst;
        logic [NAME_W-1:0] name;
    } srts_entry_t;

endpackage

@@ rtl/core/shortest_remaining_time_scheduler_top.sv @@
// Preemptive shortest-remaining-time scheduler: slot memory, scan sequencer, result register.
// Depends on srts_pkg.
//
// Load, clear and unknown beats are taken while idle and give no result. A tick beat
// scans the slots taking part, min(jobs_in_use, SLOTS), one slot per cycle through the
// single read port of the slot memory and one shared compare unit, then passes through
// the calc and done states; its result is loaded into the output register once that
// register is free. The block does not take a new beat while a tick is in progress.
// Reset and clear empty all slots at once through per-slot valid bits; no clearing
// pass is needed.
module shortest_remaining_time_scheduler_top
    import srts_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                cfg_wr_en,
    input  logic [JOBS_W-1:0]   cfg_wr_data,
    // input channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [FUNC_W-1:0]   s_func,
    input  logic [SLOT_F_W-1:0] s_slot,
    input  logic [NAME_W-1:0]   s_job_name,
    input  logic [TIME_W-1:0]   s_arrival,
    input  logic [TIME_W-1:0]   s_burst,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [TICK_W-1:0]   m_now,
    output logic                m_idle,
    output logic [SLOT_F_W-1:0] m_running_slot,
    output logic [NAME_W-1:0]   m_running_name,
    output logic                m_finished,
    output logic [TICK_W-1:0]   m_turnaround,
    output logic [TICK_W-1:0]   m_waiting
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // slot memory and per-slot valid bits
    srts_entry_t            mem [SLOTS];
    logic [SLOTS-1:0]       valid_reg;

    // control and datapath registers
    srts_state_t            state_reg, state_next;
    logic [JOBS_W-1:0]      jobs_reg;
    logic [TICK_W-1:0]      tick_reg;
    logic [CNT_W-1:0]       idx_reg;
    logic                   rd_live_reg;
    logic                   rd_ok_reg;
    logic [SLOT_W-1:0]      rd_idx_reg;
    srts_entry_t            rd_data_reg;
    logic                   found_reg;
    logic [SLOT_W-1:0]      best_idx_reg;
    srts_entry_t            best_reg;
    logic [TICK_W:0]        turn_reg;
    logic                   m_valid_reg;

    logic                   in_beat;
    logic                   load_ok;
    logic [CNT_W-1:0]       scan_cnt;
    logic                   scan_more;
    logic                   eligible;
    logic                   out_free;
    logic                   mem_we;
    logic [SLOT_W-1:0]      mem_waddr;
    srts_entry_t            mem_wdata;
    logic [TIME_W-1:0]      rem_dec;
    logic                   done_now;
    logic [TICK_W:0]        wait_full;

    assign in_beat  = s_valid && s_ready;
    assign load_ok  = (int'(s_slot) < SLOTS);
    assign out_free = !m_valid_reg || m_ready;

    // number of slots taking part
    always_comb begin
        if (int'(jobs_reg) >= SLOTS) begin
            scan_cnt = CNT_W'(SLOTS);
        end else begin
            scan_cnt = CNT_W'(jobs_reg);
        end
    end

    assign scan_more = (idx_reg < scan_cnt);

    // shared compare unit: slot read last cycle against the best so far
    assign eligible = rd_live_reg && rd_ok_reg && (rd_data_reg.rem != '0)
                      && ({{(TICK_W-TIME_W){1'b0}}, rd_data_reg.arr} <= tick_reg)
                      && (!found_reg || (rd_data_reg.rem < best_reg.rem));

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and handshake
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && (srts_func_t'(s_func) == FUNC_TICK)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!scan_more) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign done_now = (state_reg == ST_DONE) && out_free;
    assign rem_dec  = best_reg.rem - TIME_W'(1);

    // memory write port: load beat or write-back of the chosen slot
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = SLOT_W'(s_slot);
        mem_wdata = '{rem: s_burst, arr: s_arrival, burst: s_burst, name: s_job_name};
        if (in_beat && (srts_func_t'(s_func) == FUNC_LOAD) && load_ok) begin
            mem_we = 1'b1;
        end else if (done_now && found_reg) begin
            mem_we    = 1'b1;
            mem_waddr = best_idx_reg;
            mem_wdata = '{rem: rem_dec, arr: best_reg.arr, burst: best_reg.burst,
                          name: best_reg.name};
        end
    end

    // slot memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[idx_reg[SLOT_W-1:0]];
    end

    // valid bits, register and tick counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            jobs_reg  <= '0;
            tick_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                jobs_reg <= cfg_wr_data;
            end
            if (in_beat && (srts_func_t'(s_func) == FUNC_CLEAR)) begin
                valid_reg <= '0;
                tick_reg  <= '0;
            end else begin
                if (mem_we) begin
                    valid_reg[mem_waddr] <= 1'b1;
                end
                if (done_now && (tick_reg != TICK_MAX)) begin
                    tick_reg <= tick_reg + TICK_W'(1);
                end
            end
        end
    end

    // scan sequencer and best-slot tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            rd_live_reg <= 1'b0;
            found_reg   <= 1'b0;
        end else begin
            rd_live_reg <= (state_reg == ST_SCAN) && scan_more;
            if (in_beat) begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end else if ((state_reg == ST_SCAN) && scan_more) begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            if (eligible) begin
                found_reg <= 1'b1;
            end
        end
    end

    // read side info and best slot payload
    always_ff @(posedge aclk) begin
        rd_ok_reg  <= valid_reg[idx_reg[SLOT_W-1:0]] && (int'(idx_reg) < SLOTS);
        rd_idx_reg <= idx_reg[SLOT_W-1:0];
        if (eligible) begin
            best_idx_reg <= rd_idx_reg;
            best_reg     <= rd_data_reg;
        end
        // turnaround of the chosen job if it finishes this tick
        if (state_reg == ST_CALC) begin
            turn_reg <= {1'b0, tick_reg} + (TICK_W+1)'(1)
                        - (TICK_W+1)'(best_reg.arr);
        end
    end

    // waiting time, clamped at zero
    always_comb begin
        if (turn_reg >= (TICK_W+1)'(best_reg.burst)) begin
            wait_full = turn_reg - (TICK_W+1)'(best_reg.burst);
        end else begin
            wait_full = '0;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (done_now) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (done_now) begin
            m_now          <= tick_reg;
            m_idle         <= !found_reg;
            m_running_slot <= found_reg ? SLOT_F_W'(best_idx_reg) : '0;
            m_running_name <= found_reg ? best_reg.name : '0;
            if (found_reg && (rem_dec == '0)) begin
                m_finished   <= 1'b1;
                m_turnaround <= turn_reg[TICK_W-1:0];
                m_waiting    <= wait_full[TICK_W-1:0];
            end else begin
                m_finished   <= 1'b0;
                m_turnaround <= '0;
                m_waiting    <= '0;
            end
        end
    end

    assign m_valid = m_valid_reg;

endmodule

@@ test/shortest_remaining_time_scheduler_top_tb.sv @@
// Self-checking testbench for shortest_remaining_time_scheduler_top: directed and random job mixes
// against an in-bench scheduler model, with random stalls on both channels.
// Depends on srts_pkg and shortest_remaining_time_scheduler_top.
module shortest_remaining_time_scheduler_top_tb
    import srts_pkg::*;
();

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = SLOTS_DEF + 16;
    localparam int HOLD_CYCLES = 400;

    // one expected tick report
    typedef struct packed {
        logic [TICK_W-1:0]   now;
        logic                idle;
        logic [SLOT_F_W-1:0] run_slot;
        logic [NAME_W-1:0]   run_name;
        logic                finished;
        logic [TICK_W-1:0]   turnaround;
        logic [TICK_W-1:0]   waiting;
    } tick_report_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [JOBS_W-1:0]   cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    logic [FUNC_W-1:0]   s_func;
    logic [SLOT_F_W-1:0] s_slot;
    logic [NAME_W-1:0]   s_job_name;
    logic [TIME_W-1:0]   s_arrival;
    logic [TIME_W-1:0]   s_burst;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [TICK_W-1:0]   m_now;
    logic                m_idle;
    logic [SLOT_F_W-1:0] m_running_slot;
    logic [NAME_W-1:0]   m_running_name;
    logic                m_finished;
    logic [TICK_W-1:0]   m_turnaround;
    logic [TICK_W-1:0]   m_waiting;

    // scheduler model state
    logic [TIME_W-1:0]   rem_q   [SLOTS_DEF];
    logic [TIME_W-1:0]   arr_q   [SLOTS_DEF];
    logic [TIME_W-1:0]   burst_q [SLOTS_DEF];
    logic [NAME_W-1:0]   name_q  [SLOTS_DEF];
    logic [TICK_W-1:0]   tick_q;
    logic [JOBS_W-1:0]   jobs_cfg;
    tick_report_t        expected_ticks[$];

    int mismatches    = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req      = 1'b0;
    bit hold_seen     = 1'b0;
    int hold_left     = 0;

    shortest_remaining_time_scheduler_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_slot         (s_slot),
        .s_job_name     (s_job_name),
        .s_arrival      (s_arrival),
        .s_burst        (s_burst),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_now          (m_now),
        .m_idle         (m_idle),
        .m_running_slot (m_running_slot),
        .m_running_name (m_running_name),
        .m_finished     (m_finished),
        .m_turnaround   (m_turnaround),
        .m_waiting      (m_waiting)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // empty every slot and rewind time
    function automatic void model_clear();
        for (int i = 0; i < SLOTS_DEF; i++) begin
            rem_q[i]   = '0;
            arr_q[i]   = '0;
            burst_q[i] = '0;
            name_q[i]  = '0;
        end
        tick_q = '0;
    endfunction

    // advance the scheduler model by one accepted beat
    function automatic void srtf_apply(input srts_func_t f, input logic [SLOT_F_W-1:0] slot,
                                       input logic [NAME_W-1:0] name,
                                       input logic [TIME_W-1:0] arr,
                                       input logic [TIME_W-1:0] len);
        int           span;
        int           pick;
        tick_report_t rpt;
        logic [TICK_W:0] turn;
        case (f)
            FUNC_LOAD: begin
                name_q[slot]  = name;
                arr_q[slot]   = arr;
                burst_q[slot] = len;
                rem_q[slot]   = len;
            end
            FUNC_CLEAR: begin
                model_clear();
            end
            FUNC_TICK: begin
                span = (int'(jobs_cfg) < SLOTS_DEF) ? int'(jobs_cfg) : SLOTS_DEF;
                pick = -1;
                // least remaining time among arrived jobs, lowest slot on a tie
                for (int i = 0; i < span; i++) begin
                    if (rem_q[i] != '0 && TICK_W'(arr_q[i]) <= tick_q) begin
                        if (pick < 0 || rem_q[i] < rem_q[pick]) pick = i;
                    end
                end
                rpt = '0;
                rpt.now = tick_q;
                if (pick < 0) begin
                    rpt.idle = 1'b1;
                end else begin
                    rem_q[pick]  = rem_q[pick] - TIME_W'(1);
                    rpt.run_slot = pick[SLOT_F_W-1:0];
                    rpt.run_name = name_q[pick];
                    if (rem_q[pick] == '0) begin
                        rpt.finished   = 1'b1;
                        turn           = {1'b0, tick_q} + (TICK_W+1)'(1)
                                         - (TICK_W+1)'(arr_q[pick]);
                        rpt.turnaround = turn[TICK_W-1:0];
                        // clamp at zero in case time got stuck at its maximum
                        rpt.waiting    = (turn >= (TICK_W+1)'(burst_q[pick])) ?
                                         TICK_W'(turn - (TICK_W+1)'(burst_q[pick])) : '0;
                    end
                end
                expected_ticks.push_back(rpt);
                if (tick_q != TICK_MAX) tick_q = tick_q + TICK_W'(1);
            end
            default: ;
        endcase
    endfunction

    // result side ready, with random stalls and a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_seen <= 1'b0;
            hold_left <= 0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready   <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string fname, input logic [TICK_W-1:0] want,
                               input logic [TICK_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            mismatches++;
        end
    endtask

    // compare each result beat with the oldest expected report
    always @(posedge aclk) begin : result_check
        tick_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_ticks.size() == 0) begin
                $error("result beat with no report expected");
                mismatches++;
            end else begin
                want = expected_ticks.pop_front();
                check_field("now", want.now, m_now);
                check_field("idle", TICK_W'(want.idle), TICK_W'(m_idle));
                check_field("running_slot", TICK_W'(want.run_slot),
                            TICK_W'(m_running_slot));
                check_field("running_name", TICK_W'(want.run_name),
                            TICK_W'(m_running_name));
                check_field("finished", TICK_W'(want.finished), TICK_W'(m_finished));
                check_field("turnaround", want.turnaround, m_turnaround);
                check_field("waiting", want.waiting, m_waiting);
            end
        end
    end

    // send one input beat; valid stays up for the next beat unless a gap follows
    task automatic send_beat(input srts_func_t f, input logic [SLOT_F_W-1:0] slot,
                             input logic [NAME_W-1:0] name, input logic [TIME_W-1:0] arr,
                             input logic [TIME_W-1:0] len);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_func     <= f;
        s_slot     <= slot;
        s_job_name <= name;
        s_arrival  <= arr;
        s_burst    <= len;
        do @(posedge aclk); while (!s_ready);
        srtf_apply(f, slot, name, arr, len);
    endtask

    // beat whose payload fields are don't-care
    task automatic send_op(input srts_func_t f);
        send_beat(f, SLOT_F_W'($urandom), NAME_W'($urandom), TIME_W'($urandom),
                  TIME_W'($urandom));
    endtask

    // stop sending and wait for every report plus the block's tail latency
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_jobs(input logic [JOBS_W-1:0] v);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        jobs_cfg     = v;
    endtask

    // load a job, mostly into a taking-part slot with near arrival and short burst
    task automatic load_random_job();
        logic [SLOT_F_W-1:0] slot;
        logic [TIME_W-1:0]   arr;
        logic [TIME_W-1:0]   len;
        int                  span;
        span = (int'(jobs_cfg) > SLOTS_DEF) ? SLOTS_DEF : int'(jobs_cfg);
        if (span != 0 && $urandom_range(3) != 0) slot = SLOT_F_W'($urandom_range(span - 1));
        else slot = SLOT_F_W'($urandom);
        if ($urandom_range(9) == 0) arr = TIME_W'($urandom);
        else arr = tick_q[TIME_W-1:0] + TIME_W'($urandom_range(10));
        case ($urandom_range(9))
            0: len = TIME_W'($urandom);
            1: len = '0;
            default: len = TIME_W'($urandom_range(1, 8));
        endcase
        send_beat(FUNC_LOAD, slot, NAME_W'($urandom), arr, len);
    endtask

    // hand-picked cases: register extremes, ties, late arrival, reload, clear
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_idle_pct <= 0;
        // no slots take part right after reset
        send_beat(FUNC_LOAD, 4'd0, 8'h11, 16'd0, 16'd3);
        send_op(FUNC_TICK);
        send_op(FUNC_NONE);
        // register above slot count acts as all slots
        set_jobs(JOBS_W'(31));
        send_beat(FUNC_LOAD, 4'd15, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_beat(FUNC_LOAD, 4'd1, 8'h22, 16'd0, 16'd3);
        send_beat(FUNC_LOAD, 4'd2, 8'h33, 16'd3, 16'd1);
        send_beat(FUNC_LOAD, 4'd3, 8'h44, 16'd0, 16'd0);
        repeat (3) send_op(FUNC_TICK);
        // rewrite a slot whose job has arrived but not yet run
        send_beat(FUNC_LOAD, 4'd1, 8'h55, 16'd0, 16'd2);
        repeat (5) send_op(FUNC_TICK);
        // clear keeps the register
        send_op(FUNC_CLEAR);
        send_op(FUNC_TICK);
        set_jobs(JOBS_W'(SLOTS_DEF));
        send_beat(FUNC_LOAD, 4'd0, 8'hAA, 16'd0, 16'd1);
        send_op(FUNC_TICK);
        send_beat(FUNC_LOAD, 4'd15, 8'h5A, 16'd0, 16'd2);
        repeat (2) send_op(FUNC_TICK);
        // top slot drops out
        set_jobs(JOBS_W'(SLOTS_DEF - 1));
        send_op(FUNC_TICK);
        drain_results();
    endtask

    // random job sets run to completion, with stray beats mixed in
    task automatic test_random(input int budget, input int spct, input int rpct);
        int                sent;
        int                nticks;
        logic [JOBS_W-1:0] v;
        send_idle_pct  = spct;
        recv_idle_pct <= rpct;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(3) == 0) begin
                case ($urandom_range(4))
                    0: v = '0;
                    1: v = JOBS_W'(SLOTS_DEF);
                    2: v = JOBS_W'($urandom_range(17, 31));
                    default: v = JOBS_W'($urandom_range(1, SLOTS_DEF));
                endcase
                set_jobs(v);
            end
            if ($urandom_range(4) != 0) begin
                send_op(FUNC_CLEAR);
                sent++;
            end
            repeat ($urandom_range(1, 6)) begin
                load_random_job();
                sent++;
            end
            nticks = $urandom_range(4, 40);
            repeat (nticks) begin
                case ($urandom_range(19))
                    0: send_op(FUNC_NONE);
                    1: begin
                        load_random_job();
                        sent++;
                    end
                    default: ;
                endcase
                send_op(FUNC_TICK);
                sent++;
            end
        end
        drain_results();
    endtask

    // long result hold-off so the block backs up, then a full pause to drain
    task automatic test_output_stall();
        send_idle_pct  = 0;
        recv_idle_pct <= 0;
        set_jobs(JOBS_W'(5));
        send_op(FUNC_CLEAR);
        for (int k = 0; k < 5; k++) begin
            send_beat(FUNC_LOAD, SLOT_F_W'(k), NAME_W'(8'h80 + k), '0, TIME_W'(k + 2));
        end
        hold_req <= ~hold_req;
        repeat (30) send_op(FUNC_TICK);
        drain_results();
        repeat (10) send_op(FUNC_TICK);
        drain_results();
    endtask

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_func      <= FUNC_LOAD;
        s_slot      <= '0;
        s_job_name  <= '0;
        s_arrival   <= '0;
        s_burst     <= '0;
        model_clear();
        jobs_cfg = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random(330, 17, 81);
        test_random(330, 81, 17);
        test_random(340, 0, 0);
        test_output_stall();
        drain_results();

        if (mismatches == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/srts_pkg.sv
rtl/core/shortest_remaining_time_scheduler_top.sv
test/shortest_remaining_time_scheduler_top_tb.sv
